// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/fclp_pkg.sv =====
// Types and constants of the FTP control line parser.
`default_nettype none
package fclp_pkg;

   localparam int MaxResults = 6;
   localparam int CountW     = 3;
   localparam int PosW       = 3;
   localparam int CodeW      = 10;
   localparam int QueueDepth = 2;

   localparam logic [7:0] CH_CR   = 8'd13;
   localparam logic [7:0] CH_LF   = 8'd10;
   localparam logic [7:0] CH_SP   = 8'd32;
   localparam logic [7:0] CH_DASH = 8'h2d;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;

   typedef enum logic [2:0] {
      KIND_CMD      = 3'd0,
      KIND_ARG      = 3'd1,
      KIND_REPLY    = 3'd2,
      KIND_LINE_END = 3'd3,
      KIND_ERROR    = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_TRUNCATED = 2'd1,
      ERR_MALFORMED = 2'd2
   } err_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
   } entry_type;

   // All results caused by one transaction.
   typedef struct packed {
      logic [CountW-1:0]               count;
      entry_type [MaxResults-1:0]      entry;
      logic                            is_resp;
      logic [CodeW-1:0]                code;
      err_type                         err;
   } bundle_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

endpackage
`default_nettype wire

// ===== hdl/fclp_front.sv =====
// Front end: line state and classification of each byte into a result bundle.
`default_nettype none
module fclp_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           text_byte,
   input  logic                 end_of_data,
   output fclp_pkg::bundle_type bundle,
   output logic                 bundle_valid
);
   import fclp_pkg::*;

   logic [PosW-1:0]  pos_ff,  pos_in;
   logic             resp_ff, resp_in;
   logic             arg_ff,  arg_in;
   logic             crp_ff,  crp_in;
   logic [CodeW-1:0] code_ff, code_in;
   logic [7:0]       held_ff [3];
   logic [7:0]       held_in [3];

   always_comb begin : classify
      logic [7:0]        cb [2];
      logic [1:0]        nc;
      logic [7:0]        cmd [4];
      logic [2:0]        ncmd;
      logic [CountW-1:0] n;
      logic [7:0]        x;

      pos_in  = pos_ff;
      resp_in = resp_ff;
      arg_in  = arg_ff;
      crp_in  = crp_ff;
      code_in = code_ff;
      for (int i = 0; i < 3; i++) held_in[i] = held_ff[i];
      cb[0] = text_byte;
      cb[1] = text_byte;
      nc    = 2'd0;
      for (int i = 0; i < 4; i++) cmd[i] = 8'd0;
      ncmd  = 3'd0;
      n     = '0;
      x     = 8'd0;
      bundle = '0;

      if (end_of_data) begin
         bundle.entry[0] = '{kind: KIND_ERROR, data: 8'd0};
         bundle.err = (pos_ff == '0 && !crp_ff) ? ERR_TRUNCATED : ERR_MALFORMED;
         n = CountW'(1);
         pos_in = '0; resp_in = 1'b0; arg_in = 1'b0; crp_in = 1'b0; code_in = '0;
      end else if (crp_ff && text_byte == CH_LF) begin
         if (pos_ff == '0) begin
            bundle.entry[0] = '{kind: KIND_ERROR, data: 8'd0};
            bundle.err = ERR_MALFORMED;
            n = CountW'(1);
         end else begin
            if (pos_ff < PosW'(4)) begin
               for (int i = 0; i < 3; i++) cmd[i] = held_ff[i];
               ncmd = pos_ff;
            end
            for (int j = 0; j < 3; j++) begin
               if (3'(j) < ncmd) begin
                  if (!arg_in && cmd[j] == CH_SP) begin
                     arg_in = 1'b1;
                  end else begin
                     bundle.entry[n] = '{kind: (arg_in ? KIND_ARG : KIND_CMD), data: cmd[j]};
                     n = n + CountW'(1);
                  end
               end
            end
            bundle.entry[n] = '{kind: KIND_LINE_END, data: 8'd0};
            n = n + CountW'(1);
            bundle.is_resp = (pos_ff == PosW'(4)) && resp_ff;
            bundle.code    = bundle.is_resp ? code_ff : '0;
         end
         pos_in = '0; resp_in = 1'b0; arg_in = 1'b0; crp_in = 1'b0; code_in = '0;
      end else begin
         if (crp_ff) begin
            cb[0]  = CH_CR;
            nc     = (text_byte == CH_CR) ? 2'd1 : 2'd2;
            crp_in = (text_byte == CH_CR);
         end else if (text_byte == CH_CR) begin
            crp_in = 1'b1;
         end else begin
            nc = 2'd1;
         end
         for (int k = 0; k < 2; k++) begin
            if (2'(k) < nc) begin
               x    = cb[k];
               ncmd = 3'd0;
               if (pos_in < PosW'(3)) begin
                  held_in[pos_in[1:0]] = x;
                  pos_in = pos_in + PosW'(1);
               end else if (pos_in == PosW'(3)) begin
                  pos_in = PosW'(4);
                  if (is_digit(held_in[0]) && is_digit(held_in[1]) && is_digit(held_in[2])
                      && (x == CH_SP || x == CH_DASH)) begin
                     resp_in = 1'b1;
                     code_in = CodeW'(held_in[0][3:0]) * CodeW'(100)
                             + CodeW'(held_in[1][3:0]) * CodeW'(10)
                             + CodeW'(held_in[2][3:0]);
                  end else begin
                     resp_in = 1'b0;
                     for (int i = 0; i < 3; i++) cmd[i] = held_in[i];
                     cmd[3] = x;
                     ncmd   = 3'd4;
                  end
               end else if (resp_in) begin
                  bundle.entry[n] = '{kind: KIND_REPLY, data: x};
                  n = n + CountW'(1);
               end else begin
                  cmd[0] = x;
                  ncmd   = 3'd1;
               end
               for (int j = 0; j < 4; j++) begin
                  if (3'(j) < ncmd) begin
                     if (!arg_in && cmd[j] == CH_SP) begin
                        arg_in = 1'b1;
                     end else begin
                        bundle.entry[n] = '{kind: (arg_in ? KIND_ARG : KIND_CMD),
                                            data: cmd[j]};
                        n = n + CountW'(1);
                     end
                  end
               end
            end
         end
      end
      bundle.count = n;
      bundle_valid = (n != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         resp_ff <= 1'b0;
         arg_ff  <= 1'b0;
         crp_ff  <= 1'b0;
         code_ff <= '0;
      end else if (accept) begin
         pos_ff  <= pos_in;
         resp_ff <= resp_in;
         arg_ff  <= arg_in;
         crp_ff  <= crp_in;
         code_ff <= code_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < 3; i++) held_ff[i] <= held_in[i];
      end
   end

endmodule
`default_nettype wire

// ===== hdl/fclp_queue.sv =====
// Two-entry queue of result bundles between front and back.
`default_nettype none
module fclp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  fclp_pkg::bundle_type wr_data,
   output logic                 full,
   input  logic                 rd_en,
   output fclp_pkg::bundle_type rd_data,
   output logic                 empty
);
   import fclp_pkg::*;

   localparam int PtrW = $clog2(QueueDepth);

   bundle_type      mem_ff [QueueDepth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PtrW:0]   count_ff,  count_in;

   assign full    = (count_ff == (PtrW+1)'(QueueDepth));
   assign empty   = (count_ff == '0);
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QueueDepth-1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QueueDepth-1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      case ({wr_en, rd_en})
         2'b10:   count_in = count_ff + (PtrW+1)'(1);
         2'b01:   count_in = count_ff - (PtrW+1)'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/fclp_back.sv =====
// Back end: walks the head bundle and presents its results, one per pop.
`default_nettype none
module fclp_back (
   input  logic                 clock,
   input  logic                 reset,
   input  fclp_pkg::bundle_type head,
   input  logic                 head_valid,
   output logic                 head_done,
   input  logic                 pop,
   output logic [2:0]           kind,
   output logic [7:0]           out_byte,
   output logic                 is_response,
   output logic [9:0]           reply_code,
   output logic [1:0]           error_code,
   output logic                 last
);
   import fclp_pkg::*;

   logic [CountW-1:0] idx_ff, idx_in;
   entry_type         cur;
   logic              take;

   assign cur         = head.entry[idx_ff];
   assign kind        = cur.kind;
   assign out_byte    = cur.data;
   assign is_response = (cur.kind == KIND_LINE_END) && head.is_resp;
   assign reply_code  = is_response ? head.code : '0;
   assign error_code  = (cur.kind == KIND_ERROR) ? head.err : ERR_NONE;
   assign last        = (idx_ff == head.count - CountW'(1));
   assign take        = pop && head_valid;
   assign head_done   = take && last;

   always_comb begin
      idx_in = idx_ff;
      if (head_done) begin
         idx_in = '0;
      end else if (take) begin
         idx_in = idx_ff + CountW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/ftp_control_line_parser.sv =====
// FTP control line parser, top level.
// Accepts one control-stream byte (or an end-of-data mark) per cycle while
// full is low, and returns its results (0 to 5 per transaction, last marking
// the final one) through a queue interface, one result per cycle while pop
// is high. A transaction's results are classified in the cycle it is accepted
// and reach the result ports once all earlier bundles have been popped. The
// queue holds two bundles between the classifier and the result port, so new
// bytes are accepted while earlier results still wait, and it absorbs bursts.
// Transactions that produce no result (held header bytes, a pending CR) still
// need a free queue slot to be accepted.
`default_nettype none
`include "assert_macros.svh"
module ftp_control_line_parser (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_text_byte,
   input  logic       req_end_of_data,
   output logic       empty,
   input  logic       pop,
   output logic [2:0] rsp_kind,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_is_response,
   output logic [9:0] rsp_reply_code,
   output logic [1:0] rsp_error_code,
   output logic       rsp_last
);
   import fclp_pkg::*;

   logic       accept;
   bundle_type new_bundle;
   logic       new_valid;
   bundle_type head;
   logic       head_done;

   assign accept = push && !full;

   fclp_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .text_byte    (req_text_byte),
      .end_of_data  (req_end_of_data),
      .bundle       (new_bundle),
      .bundle_valid (new_valid)
   );

   fclp_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (accept && new_valid),
      .wr_data (new_bundle),
      .full    (full),
      .rd_en   (head_done),
      .rd_data (head),
      .empty   (empty)
   );

   fclp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .head_valid  (!empty),
      .head_done   (head_done),
      .pop         (pop),
      .kind        (rsp_kind),
      .out_byte    (rsp_out_byte),
      .is_response (rsp_is_response),
      .reply_code  (rsp_reply_code),
      .error_code  (rsp_error_code),
      .last        (rsp_last)
   );

   `ASSERT_IMPLIES(a_code_on_resp_end, clock, reset, !empty && rsp_reply_code != 10'd0, rsp_kind == KIND_LINE_END && rsp_is_response)
   `ASSERT_IMPLIES(a_error_alone, clock, reset, !empty && rsp_kind == KIND_ERROR, rsp_last && rsp_error_code != ERR_NONE)
   `ASSERT_NEXT(a_eod_queued, clock, reset, !reset && push && !full && req_end_of_data, !empty)

endmodule
`default_nettype wire
